[design/lpp_pkg.sv]
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types and constants for the lidar point to pixel projector.
// ----------------------------------------------------------------------------
package lpp_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgR0PairA = 3'd0,
    CfgR0PairB = 3'd1,
    CfgR1PairA = 3'd2,
    CfgR1PairB = 3'd3,
    CfgR2PairA = 3'd4,
    CfgR2PairB = 3'd5,
    CfgCrop    = 3'd6
  } cfg_idx_e;

  localparam int unsigned NumRegs   = 7;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CropW     = 48;

  // Row sums are exact in 58 signed bits.
  localparam int unsigned SumW      = 58;
  localparam int unsigned QuoW      = 16;
  // Divider stages: magnitude stage, one stage per quotient bit, saturation.
  localparam int unsigned DivLat    = QuoW + 2;

  // Twenty metres in Q.8 units, and full colour scale.
  localparam logic [12:0] DistRef   = 13'd5120;
  localparam logic [7:0]  ColourMax = 8'd255;
  // Reciprocal of five in Q.16, exact for the narrow range used.
  localparam logic [13:0] RecipFive = 14'd13108;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
  } in_t;

  typedef struct packed {
    logic               drawn;
    logic signed [15:0] pixel_u;
    logic signed [15:0] pixel_v;
    logic [7:0]         red_level;
    logic [7:0]         green_level;
  } out_t;

  // Pipeline control handed to the dividers.
  typedef struct packed {
    logic en;
  } pipe_ctrl_t;

endpackage

[design/lpp_div.sv]
// ----------------------------------------------------------------------------
// lpp_div
// Pipelined signed divider, one quotient bit per stage, result truncated
// toward zero and saturated to 16 signed bits.
// ----------------------------------------------------------------------------
module lpp_div (
  input  logic                                clk_i,
  input  lpp_pkg::pipe_ctrl_t                 ctrl_i,
  input  logic signed [lpp_pkg::SumW-1:0]     num_i,
  input  logic signed [lpp_pkg::SumW-1:0]     den_i,
  output logic signed [lpp_pkg::QuoW-1:0]     quo_o
);
  import lpp_pkg::*;

  localparam int unsigned WideW = SumW + QuoW;

  logic [SumW-1:0] rem_q [QuoW+1];
  logic [SumW-1:0] den_q [QuoW+1];
  logic [QuoW-1:0] quo_q [QuoW+1];
  logic            neg_q [QuoW+1];
  logic            ovf_q [QuoW+1];

  logic [SumW-1:0] mag_n;
  logic [SumW-1:0] mag_d;

  // Magnitudes, result sign and overflow when the quotient needs 17 bits.
  assign mag_n = num_i[SumW-1] ? SumW'(-num_i) : SumW'(num_i);
  assign mag_d = den_i[SumW-1] ? SumW'(-den_i) : SumW'(den_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      rem_q[0] <= mag_n;
      den_q[0] <= mag_d;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[SumW-1] ^ den_i[SumW-1];
      ovf_q[0] <= {{QuoW{1'b0}}, mag_n} >= {mag_d, {QuoW{1'b0}}};
    end
  end

  // Restoring steps, most significant quotient bit first.
  for (genvar k = 1; k <= QuoW; k++) begin : g_step
    localparam int unsigned Bit = QuoW - k;
    logic [WideW-1:0] shifted;
    logic             take;
    logic [WideW-1:0] diff;

    assign shifted = {{QuoW{1'b0}}, den_q[k-1]} << Bit;
    assign take    = {{QuoW{1'b0}}, rem_q[k-1]} >= shifted;
    assign diff    = {{QuoW{1'b0}}, rem_q[k-1]} - shifted;

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        rem_q[k] <= take ? diff[SumW-1:0] : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= quo_q[k-1] | (QuoW'(take) << Bit);
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // Apply the sign and saturate.
  logic [QuoW-1:0] mag_q;
  logic            big_pos;
  logic            big_neg;

  assign mag_q   = quo_q[QuoW];
  assign big_pos = ovf_q[QuoW] || mag_q[QuoW-1];
  assign big_neg = ovf_q[QuoW] || (mag_q > {1'b1, {(QuoW-1){1'b0}}});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      if (!neg_q[QuoW]) begin
        quo_o <= big_pos ? {1'b0, {(QuoW-1){1'b1}}} : mag_q;
      end else begin
        quo_o <= big_neg ? {1'b1, {(QuoW-1){1'b0}}} : (~mag_q + 1'b1);
      end
    end
  end

endmodule

[design/lidar_point_to_pixel_projector_core.sv]
// ----------------------------------------------------------------------------
// lidar_point_to_pixel_projector_core
// Crops a lidar point, projects it through a 3x4 matrix to a pixel and
// gives a distance colour.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid_i/in_stall_o   in_data_i (x, y, z)
//  out      source     out_valid_o/out_stall_i out_data_o (drawn, u, v, colour)
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One point per cycle unless a stalled result is held; the crop, multiply and
// sum stages feed the divider. Reset clears the valid bits and the
// configuration registers. A stall on a valid output holds the whole pipeline,
// so in_stall_o is high while a result waits; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lidar_point_to_pixel_projector_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lpp_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lpp_pkg::out_t                    out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lpp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lpp_pkg::CfgDataW-1:0]     cfg_data_i
);
  import lpp_pkg::*;

  // Configuration registers.
  logic [CfgDataW-1:0] coef_q [6];
  logic [CropW-1:0]    crop_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) coef_q[i] <= '0;
      crop_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgR0PairA: coef_q[0] <= cfg_data_i;
        CfgR0PairB: coef_q[1] <= cfg_data_i;
        CfgR1PairA: coef_q[2] <= cfg_data_i;
        CfgR1PairB: coef_q[3] <= cfg_data_i;
        CfgR2PairA: coef_q[4] <= cfg_data_i;
        CfgR2PairB: coef_q[5] <= cfg_data_i;
        CfgCrop:    crop_q    <= cfg_data_i[CropW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: everything moves unless a finished result is held.
  pipe_ctrl_t ctrl;
  logic       in_acc;

  assign ctrl.en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !ctrl.en;
  assign in_acc     = in_valid_i && ctrl.en;

  logic vld_q [3];

  // Stage 1: crop test and the scaled distance for the colour.
  logic signed [24:0] xe, ye, ze, ay, mx, my, mz, dd;
  logic [24:0]        dabs;
  logic               pass;

  assign xe   = {in_data_i.point_x[23], in_data_i.point_x};
  assign ye   = {in_data_i.point_y[23], in_data_i.point_y};
  assign ze   = {in_data_i.point_z[23], in_data_i.point_z};
  assign ay   = ye[24] ? -ye : ye;
  assign mx   = {{9{crop_q[47]}}, crop_q[47:32]};
  assign my   = {{9{crop_q[31]}}, crop_q[31:16]};
  assign mz   = {{9{crop_q[15]}}, crop_q[15:0]};
  assign pass = !(xe > mx) && !xe[24] && !(ay > my) && !(ze < mz);
  assign dd   = xe - 25'(DistRef);
  assign dabs = dd[24] ? 25'(-dd) : 25'(dd);

  logic signed [23:0] x1_q, y1_q, z1_q;
  logic               pass1_q, far1_q;
  logic [20:0]        t1_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.en) begin
      x1_q    <= in_data_i.point_x;
      y1_q    <= in_data_i.point_y;
      z1_q    <= in_data_i.point_z;
      pass1_q <= pass;
      far1_q  <= dabs >= 25'(DistRef);
      t1_q    <= {dabs[12:0], 8'b0} - {8'b0, dabs[12:0]};
    end
  end

  // Stage 2: nine products, three constant terms and the colour levels.
  logic signed [55:0] prod_q [3][3];
  logic signed [39:0] kterm_q [3];
  logic               pass2_q;
  logic [7:0]         red2_q, green2_q;

  logic [24:0] rprod;
  logic [7:0]  rq;
  logic [20:0] rback;
  logic [7:0]  gq;

  assign rprod = 25'(t1_q[20:10]) * 25'(RecipFive);
  assign rq    = rprod[23:16];
  assign rback = {1'b0, rq, 12'b0} + {3'b0, rq, 10'b0};
  assign gq    = ColourMax - rq - 8'(t1_q != rback);

  always_ff @(posedge clk_i) begin
    if (ctrl.en) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= $signed(coef_q[2*r][63:32]) * x1_q;
        prod_q[r][1] <= $signed(coef_q[2*r][31:0]) * y1_q;
        prod_q[r][2] <= $signed(coef_q[2*r+1][63:32]) * z1_q;
        kterm_q[r]   <= {coef_q[2*r+1][31:0], 8'b0};
      end
      pass2_q  <= pass1_q;
      red2_q   <= far1_q ? ColourMax : rq;
      green2_q <= far1_q ? 8'd0 : gq;
    end
  end

  // Stage 3: row sums and the zero divisor test.
  logic signed [SumW-1:0] sum3_q [3];
  logic signed [SumW-1:0] sum_d  [3];
  logic                   drawn3_q;
  logic [7:0]             red3_q, green3_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]) + SumW'(prod_q[r][2])
               + SumW'(kterm_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en) begin
      for (int r = 0; r < 3; r++) sum3_q[r] <= sum_d[r];
      drawn3_q <= pass2_q && (sum_d[2] != '0);
      red3_q   <= red2_q;
      green3_q <= green2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) vld_q[i] <= 1'b0;
    end else if (ctrl.en) begin
      vld_q[0] <= in_acc;
      vld_q[1] <= vld_q[0];
      vld_q[2] <= vld_q[1];
    end
  end

  // Dividers for column and row.
  logic signed [QuoW-1:0] quo_u, quo_v;

  lpp_div u_div_u (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .num_i  (sum3_q[0]),
    .den_i  (sum3_q[2]),
    .quo_o  (quo_u)
  );

  lpp_div u_div_v (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .num_i  (sum3_q[1]),
    .den_i  (sum3_q[2]),
    .quo_o  (quo_v)
  );

  // Side line that keeps flags and colour in step with the dividers.
  logic       svld_q  [DivLat];
  logic       sdrawn_q[DivLat];
  logic [7:0] sred_q  [DivLat];
  logic [7:0] sgreen_q[DivLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) svld_q[i] <= 1'b0;
    end else if (ctrl.en) begin
      svld_q[0] <= vld_q[2];
      for (int i = 1; i < DivLat; i++) svld_q[i] <= svld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en) begin
      sdrawn_q[0] <= drawn3_q;
      sred_q[0]   <= red3_q;
      sgreen_q[0] <= green3_q;
      for (int i = 1; i < DivLat; i++) begin
        sdrawn_q[i] <= sdrawn_q[i-1];
        sred_q[i]   <= sred_q[i-1];
        sgreen_q[i] <= sgreen_q[i-1];
      end
    end
  end

  // Result: a dropped point reads as all zeros.
  logic drawn_out;

  assign drawn_out              = sdrawn_q[DivLat-1];
  assign out_valid_o            = svld_q[DivLat-1];
  assign out_data_o.drawn       = drawn_out;
  assign out_data_o.pixel_u     = drawn_out ? quo_u : '0;
  assign out_data_o.pixel_v     = drawn_out ? quo_v : '0;
  assign out_data_o.red_level   = drawn_out ? sred_q[DivLat-1] : '0;
  assign out_data_o.green_level = drawn_out ? sgreen_q[DivLat-1] : '0;

  // Checks.
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.drawn |->
      out_data_o.pixel_u == '0 && out_data_o.red_level == '0)
    else $error("dropped point carries a nonzero payload");

  a_full_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.red_level == ColourMax |->
      out_data_o.green_level == '0)
    else $error("full red with nonzero green");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && vld_q[2] |=> svld_q[0])
    else $error("item lost entering the divider");

endmodule

[dv/tb_lidar_point_to_pixel_projector_core.sv]
// ----------------------------------------------------------------------------
// tb_lidar_point_to_pixel_projector_core
// Self-checking testbench for the lidar point projector. A scoreboard predicts
// the crop decision, the pixel quotients and the distance colour of every
// point, and compares each output transfer with the oldest prediction. The run
// covers several matrix and crop settings, with random bursts on the input and
// random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lidar_point_to_pixel_projector_core;
  import lpp_pkg::*;

  // Index beyond the register file; a write to it must change nothing.
  localparam logic [2:0] CfgNoReg = 3'd7;
  localparam int unsigned IdleLimit = 3000;

  // Predicts projected pixels and holds them until the block delivers them.
  class pixel_scoreboard;
    logic [63:0] coef_regs [NumRegs];
    out_t        pixel_q [$];
    int          errors;
    int          n_drawn;
    int          n_checked;

    // Registers start from their reset value of zero.
    function new();
      foreach (coef_regs[i]) coef_regs[i] = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      if (idx < NumRegs) begin
        coef_regs[idx] = (idx == CfgCrop) ? {16'd0, val[47:0]} : val;
      end
    endfunction

    function longint coef_at(int row, int col);
      logic [63:0] w;
      w = coef_regs[row * 2 + col / 2];
      return (col % 2) ? longint'($signed(w[31:0])) : longint'($signed(w[63:32]));
    endfunction

    function longint row_value(int row, longint x, longint y, longint z);
      return coef_at(row, 0) * x + coef_at(row, 1) * y + coef_at(row, 2) * z
             + coef_at(row, 3) * 256;
    endfunction

    function logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // Works out the result of one accepted point.
    function void note_point(in_t p);
      longint x, y, z, ay, mx, my, mz, s0, s1, s2, d_abs, red;
      out_t   r;
      x  = longint'(p.point_x);
      y  = longint'(p.point_y);
      z  = longint'(p.point_z);
      mx = longint'($signed(coef_regs[CfgCrop][47:32]));
      my = longint'($signed(coef_regs[CfgCrop][31:16]));
      mz = longint'($signed(coef_regs[CfgCrop][15:0]));
      ay = (y < 0) ? -y : y;
      r  = '0;
      if (!(x > mx || x < 0 || ay > my || z < mz)) begin
        s2 = row_value(2, x, y, z);
        if (s2 != 0) begin
          s0    = row_value(0, x, y, z);
          s1    = row_value(1, x, y, z);
          d_abs = (x >= 5120) ? x - 5120 : 5120 - x;
          red   = (255 * d_abs) / 5120;
          r.drawn       = 1'b1;
          r.pixel_u     = clamp16(s0 / s2);
          r.pixel_v     = clamp16(s1 / s2);
          r.red_level   = (red > 255) ? 8'd255 : red[7:0];
          r.green_level = (d_abs <= 5120) ? 8'((255 * (5120 - d_abs)) / 5120) : 8'd0;
          n_drawn++;
        end
      end
      pixel_q.push_back(r);
    endfunction

    function void check_pixel(out_t got);
      out_t exp_r;
      n_checked++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pixel_q.pop_front();
      if (got.drawn !== exp_r.drawn) begin
        $display("%0t: drawn expected %0d actual %0d", $time, exp_r.drawn, got.drawn);
        errors++;
      end
      if (got.pixel_u !== exp_r.pixel_u) begin
        $display("%0t: pixel_u expected %0d actual %0d", $time, exp_r.pixel_u, got.pixel_u);
        errors++;
      end
      if (got.pixel_v !== exp_r.pixel_v) begin
        $display("%0t: pixel_v expected %0d actual %0d", $time, exp_r.pixel_v, got.pixel_v);
        errors++;
      end
      if (got.red_level !== exp_r.red_level) begin
        $display("%0t: red_level expected %0d actual %0d", $time, exp_r.red_level,
                 got.red_level);
        errors++;
      end
      if (got.green_level !== exp_r.green_level) begin
        $display("%0t: green_level expected %0d actual %0d", $time, exp_r.green_level,
                 got.green_level);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  pixel_scoreboard sb = new();
  int burst_left = 0;
  int n_points = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int cyc = 0;

  always #10 clk_i = ~clk_i;

  lidar_point_to_pixel_projector_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Output stall pattern; its character is picked at random from four and changes during the run.
  always @(negedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc % 150 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (cyc % 5 < 2);
    endcase
  end

  // Result checking on every output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_pixel(out_data_o);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("** lidar_point_to_pixel_projector_core: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Sends one point, with random gaps between bursts. Called at a falling edge.
  task automatic send_point(in_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_data_i  = p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(p);
    n_points++;
    @(negedge clk_i);
  endtask

  task automatic send_xyz(longint x, longint y, longint z);
    in_t p;
    p.point_x = x[23:0];
    p.point_y = y[23:0];
    p.point_z = z[23:0];
    send_point(p);
  endtask

  // Waits until every predicted result has arrived.
  task automatic drain();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (sb.pixel_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_matrix(logic [63:0] r0a, logic [63:0] r0b, logic [63:0] r1a,
                             logic [63:0] r1b, logic [63:0] r2a, logic [63:0] r2b,
                             logic [63:0] crop);
    write_reg(CfgR0PairA, r0a);
    write_reg(CfgR0PairB, r0b);
    write_reg(CfgR1PairA, r1a);
    write_reg(CfgR1PairB, r1b);
    write_reg(CfgR2PairA, r2a);
    write_reg(CfgR2PairB, r2b);
    write_reg(CfgCrop, crop);
  endtask

  // Random points: mostly inside the crop box, the rest over the full range.
  task automatic random_points(int count);
    longint mx, my, mz, x, y, z;
    mx = longint'($signed(sb.coef_regs[CfgCrop][47:32]));
    my = longint'($signed(sb.coef_regs[CfgCrop][31:16]));
    mz = longint'($signed(sb.coef_regs[CfgCrop][15:0]));
    repeat (count) begin
      x = longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
      y = longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
      z = longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
      if ($urandom_range(0, 9) < 7) begin
        if (mx >= 0) x = $urandom_range(0, mx);
        if (my >= 0) y = longint'($urandom_range(0, 2 * my)) - my;
        z = mz + $urandom_range(0, 20000);
      end
      send_xyz(x, y, z);
    end
  endtask

  task automatic directed_points();
    longint mx, my, mz;
    mx = longint'($signed(sb.coef_regs[CfgCrop][47:32]));
    my = longint'($signed(sb.coef_regs[CfgCrop][31:16]));
    mz = longint'($signed(sb.coef_regs[CfgCrop][15:0]));
    send_xyz(0, 0, 0);
    send_xyz(-1, 0, 0);
    send_xyz(8388607, 8388607, 8388607);
    send_xyz(-8388608, -8388608, -8388608);
    send_xyz(mx, my, mz);
    send_xyz(mx + 1, 0, mz);
    send_xyz(mx, -my, mz);
    send_xyz(mx, my + 1, mz);
    send_xyz(mx, -my - 1, mz);
    send_xyz(mx, 0, mz - 1);
    send_xyz(5120, 0, 0);
    send_xyz(10240, 100, 50);
    send_xyz(10241, -100, 50);
    send_xyz(2560, 3, 7);
    send_xyz(1, -1, 0);
    send_xyz(15000, 256, -256);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset state: crop and matrix are zero, so every point is dropped.
    directed_points();
    drain();

    // A plausible camera: depth is forward distance, a zero depth row is hit
    // at x = 0 and drops the point.
    load_matrix({32'sd320 <<< 16, -32'sd500 <<< 16}, 64'd0,
                {32'sd240 <<< 16, 32'd0}, {-32'sd500 <<< 16, 32'd0},
                {32'sd1 <<< 16, 32'd0}, 64'd0,
                {16'd0, 16'sd20480, 16'sd5120, -16'sd512});
    write_reg(CfgNoReg, {$urandom, $urandom});
    directed_points();
    random_points(230);
    drain();

    // Extreme coefficients and the widest crop.
    load_matrix({32'h7FFFFFFF, 32'h80000000}, {32'h7FFFFFFF, 32'h80000000},
                {32'h80000000, 32'h7FFFFFFF}, {32'h80000000, 32'h7FFFFFFF},
                {32'h00000001, 32'hFFFFFFFF}, {32'h00000001, 32'h80000000},
                {16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000});
    directed_points();
    random_points(180);
    drain();

    // Tiny constant depth, so most quotients saturate.
    load_matrix({32'h00400000, 32'hFFC00000}, {32'h00100000, 32'h12345678},
                {32'hFF000000, 32'h00800000}, {32'h01000000, 32'h87654321},
                64'd0, {32'd0, 32'd1},
                {16'd0, 16'h7FFF, 16'h7FFF, 16'h8000});
    random_points(180);
    drain();

    // Fully random registers, then random matrix with a usable crop.
    load_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom});
    random_points(150);
    drain();
    load_matrix({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {16'd0, 16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                 16'($urandom)});
    random_points(150);
    drain();
    repeat (30) @(negedge clk_i);

    $display("Sent %0d points over six register settings; %0d results checked, %0d drawn.",
             n_points, sb.n_checked, sb.n_drawn);
    if (sb.errors == 0) begin
      $display("** lidar_point_to_pixel_projector_core: PASSED **");
    end else begin
      $display("** lidar_point_to_pixel_projector_core: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
design/lpp_pkg.sv
design/lpp_div.sv
design/lidar_point_to_pixel_projector_core.sv
dv/tb_lidar_point_to_pixel_projector_core.sv
